// ===== hw/rtl/gf2_64_arith_unit_top_defines.svh =====
// Assertion macros used by the controller RTL of the GF(2^64) arithmetic unit
`ifndef GF2_64_ARITH_UNIT_TOP_DEFINES_SVH
`define GF2_64_ARITH_UNIT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, masked while reset is asserted
`define GF2A_ASSERT_IMPL(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gf2a: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted
`define GF2A_ASSERT_NEXT(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gf2a: next-cycle check failed");

`else

`define GF2A_ASSERT_IMPL(label, ck, rstn, ante, cons)
`define GF2A_ASSERT_NEXT(label, ck, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/gf2a_pkg.sv =====
package gf2a_pkg;

  // Field element width and low part of the reduction polynomial
  localparam int unsigned ELEM_W   = 64;
  localparam int unsigned EXP_W    = 32;
  localparam logic [ELEM_W-1:0] GF_LOW_POLY = 64'd27;

  // Iteration counter: loaded with the index of the last iteration
  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] RECIP_LAST = 6'd62;
  localparam logic [CNT_W-1:0] POW_LAST   = 6'(EXP_W - 1);

  // Operation codes carried in tuser
  typedef enum logic [1:0] {
    OP_TIMES_X = 2'd0,
    OP_POW_X   = 2'd1,
    OP_MUL     = 2'd2,
    OP_RECIP   = 2'd3
  } op_t;

  // Source of the result register
  typedef enum logic [1:0] {
    RES_TIMES_X = 2'd0,
    RES_X       = 2'd1,
    RES_Y       = 2'd2
  } res_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load;        // take operands of an accepted item
    logic     load_x_one;  // x starts at 1 (power of x)
    logic     load_y_one;  // y starts at 1 (reciprocal)
    logic     sq;          // x <= x * x
    logic     step_x;      // after squaring, times x when exponent bit is set
    logic     mul;         // y <= x * y
    logic     capture;     // load the result register
    res_sel_t res_sel;
  } cmd_t;

endpackage

// ===== hw/rtl/gf2a_clmul.sv =====
module gf2a_clmul (
  input  logic [gf2a_pkg::ELEM_W-1:0] mul_a,
  input  logic [gf2a_pkg::ELEM_W-1:0] mul_b,
  output logic [gf2a_pkg::ELEM_W-1:0] mul_p
);

  localparam int unsigned W   = gf2a_pkg::ELEM_W;
  localparam int unsigned PW  = 2 * W - 1;
  localparam int unsigned LVL = $clog2(W);
  localparam int unsigned HW  = W - 1;

  logic [PW-1:0] tree [0:LVL][0:W-1];
  logic [PW-1:0] prod;
  logic [HW-1:0] hi;
  logic [HW+3:0] fold1;
  logic [2:0]    g;
  logic [W-1:0]  fold2;

  // Partial products, then a balanced xor tree
  always_comb begin
    for (int l = 0; l <= LVL; l++) begin
      for (int n = 0; n < W; n++) begin
        tree[l][n] = '0;
      end
    end
    for (int i = 0; i < W; i++) begin
      tree[0][i] = mul_b[i] ? (PW'(mul_a) << i) : '0;
    end
    for (int l = 1; l <= LVL; l++) begin
      for (int n = 0; n < (W >> l); n++) begin
        tree[l][n] = tree[l-1][2*n] ^ tree[l-1][2*n+1];
      end
    end
    prod = tree[LVL][0];
  end

  // Reduce modulo x^64 + x^4 + x^3 + x + 1 in two folds
  always_comb begin
    hi    = prod[PW-1:W];
    fold1 = {4'b0, hi} ^ {3'b0, hi, 1'b0} ^ {1'b0, hi, 3'b0} ^ {hi, 4'b0};
    g     = fold1[HW+3:W];
    fold2 = {61'b0, g} ^ {60'b0, g, 1'b0} ^ {58'b0, g, 3'b0} ^ {57'b0, g, 4'b0};
    mul_p = prod[W-1:0] ^ fold1[W-1:0] ^ fold2;
  end

endmodule

// ===== hw/rtl/gf2a_dpath.sv =====
module gf2a_dpath (
  input  logic                          clk,
  input  gf2a_pkg::cmd_t                cmd,
  input  logic [gf2a_pkg::ELEM_W-1:0]   operand_a,
  input  logic [gf2a_pkg::ELEM_W-1:0]   operand_b,
  input  logic [gf2a_pkg::EXP_W-1:0]    exponent,
  output logic [gf2a_pkg::ELEM_W-1:0]   result
);

  localparam int unsigned W  = gf2a_pkg::ELEM_W;
  localparam int unsigned EW = gf2a_pkg::EXP_W;

  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic [W-1:0]  mul_b;
  logic [W-1:0]  mul_p;

  function automatic logic [W-1:0] times_x(input logic [W-1:0] v);
    times_x = {v[W-2:0], 1'b0} ^ (v[W-1] ? gf2a_pkg::GF_LOW_POLY : '0);
  endfunction

  // Shared field multiplier: x by x when squaring, x by y otherwise
  assign mul_b = cmd.sq ? x_r : y_r;

  gf2a_clmul u_clmul (
    .mul_a (x_r),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // Operand registers and exponent shifter
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    e_nxt = e_r;
    if (cmd.load) begin
      x_nxt = cmd.load_x_one ? W'(1) : operand_a;
      y_nxt = cmd.load_y_one ? W'(1) : operand_b;
      e_nxt = exponent;
    end else if (cmd.sq) begin
      x_nxt = (cmd.step_x && e_r[EW-1]) ? times_x(mul_p) : mul_p;
      e_nxt = {e_r[EW-2:0], 1'b0};
    end else if (cmd.mul) begin
      y_nxt = mul_p;
    end
  end

  // Result register
  always_comb begin
    res_nxt = res_r;
    if (cmd.capture) begin
      case (cmd.res_sel)
        gf2a_pkg::RES_TIMES_X: res_nxt = times_x(x_r);
        gf2a_pkg::RES_X:       res_nxt = x_r;
        gf2a_pkg::RES_Y:       res_nxt = y_r;
        default:               res_nxt = y_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    e_r   <= e_nxt;
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

// ===== hw/rtl/gf2a_ctrl.sv =====
`include "gf2_64_arith_unit_top_defines.svh"

module gf2a_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  gf2a_pkg::op_t       in_op,
  output logic                out_tvalid,
  input  logic                out_tready,
  output gf2a_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ   = 4'b0010,
    S_MUL  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  gf2a_pkg::op_t                 op_r, op_nxt;
  logic [gf2a_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Sequence the squarings and multiplications of each operation
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load       = 1'b1;
          cmd.load_x_one = (in_op == gf2a_pkg::OP_POW_X);
          cmd.load_y_one = (in_op == gf2a_pkg::OP_RECIP);
          op_nxt         = in_op;
          cnt_nxt        = (in_op == gf2a_pkg::OP_POW_X) ? gf2a_pkg::POW_LAST
                                                         : gf2a_pkg::RECIP_LAST;
          case (in_op)
            gf2a_pkg::OP_TIMES_X: state_nxt = S_FIN;
            gf2a_pkg::OP_POW_X:   state_nxt = S_SQ;
            gf2a_pkg::OP_MUL:     state_nxt = S_MUL;
            gf2a_pkg::OP_RECIP:   state_nxt = S_SQ;
            default:              state_nxt = S_FIN;
          endcase
        end
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        cmd.step_x = (op_r == gf2a_pkg::OP_POW_X);
        if (op_r == gf2a_pkg::OP_RECIP) begin
          state_nxt = S_MUL;
        end else if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (op_r == gf2a_pkg::OP_MUL || cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_FIN: begin
        case (op_r)
          gf2a_pkg::OP_TIMES_X: cmd.res_sel = gf2a_pkg::RES_TIMES_X;
          gf2a_pkg::OP_POW_X:   cmd.res_sel = gf2a_pkg::RES_X;
          default:              cmd.res_sel = gf2a_pkg::RES_Y;
        endcase
        // Hand over only when the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= gf2a_pkg::OP_TIMES_X;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `GF2A_ASSERT_IMPL(a_capture_free, clk, rst_n, cmd.capture, !out_valid_r || out_tready)
  `GF2A_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `GF2A_ASSERT_IMPL(a_sq_op, clk, rst_n, state_r == S_SQ, op_r == gf2a_pkg::OP_POW_X || op_r == gf2a_pkg::OP_RECIP)
  `GF2A_ASSERT_IMPL(a_mul_op, clk, rst_n, state_r == S_MUL, op_r == gf2a_pkg::OP_MUL || op_r == gf2a_pkg::OP_RECIP)
  `GF2A_ASSERT_IMPL(a_cnt_range, clk, rst_n, state_r != S_IDLE, cnt_r <= gf2a_pkg::RECIP_LAST)

endmodule

// ===== hw/rtl/gf2_64_arith_unit_top.sv =====
// Times x, multiply, power of x and reciprocal take differing times from input transfer
// to the earliest result transfer; one shared field multiplier sets these.
// A new item is taken in the cycle after the previous one reaches the result register,
// so the unit does not overlap items.
// Synchronous active-low reset returns the controller to idle and empties the
// result register; operand and result payload registers are not reset.
module gf2_64_arith_unit_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // operand_a[63:0], operand_b[127:64], exponent[159:128]
  input  logic [1:0]   in_tuser,   // operation[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // result[63:0]
);

  gf2a_pkg::cmd_t cmd;

  // Sequence control
  gf2a_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (gf2a_pkg::op_t'(in_tuser)),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Operand registers, field multiplier and result register
  gf2a_dpath u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .operand_a (in_tdata[63:0]),
    .operand_b (in_tdata[127:64]),
    .exponent  (in_tdata[159:128]),
    .result    (out_tdata)
  );

endmodule
